// ===== rtl/lhmg_pkg.sv =====
// Shared constants for the load history mode governor.
// Used by the top level; depends on nothing.
package lhmg_pkg;

    localparam int LOAD_W = 14;
    localparam int LOAD_MAX_INT = 10000;
    localparam logic [LOAD_W-1:0] LOAD_MAX = 14'd10000;

    localparam int DEF_HISTORY_DEPTH = 60;
    localparam int DEF_SHORT_WINDOW = 5;

    localparam logic [LOAD_W-1:0] DEF_HIGH_THRESHOLD = 14'd3300;
    localparam logic [LOAD_W-1:0] DEF_LOW_THRESHOLD = 14'd2500;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic REG_HIGH_THRESHOLD = 1'b0;
    localparam logic REG_LOW_THRESHOLD = 1'b1;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_PERF = 2'd1;
    localparam logic [1:0] MODE_SAVER = 2'd2;

endpackage

// ===== rtl/load_history_mode_governor.sv =====
// Top level of the load history mode governor: sequencer, running sums and APB registers.
// Depends on lhmg_pkg, lhmg_hist_mem and lhmg_serial_div.
// Each request carries one load sample and yields one result with the short and long
// truncated means and a mode request. After acceptance, states S_BACK, S_OLD and S_ADD
// read the leaving samples from the history memory and update the sums. S_DIV_S follows,
// and then there are two passes of the shared one-bit-per-cycle divider (14 quotient bits
// each). The next request is taken only once the block is back in S_IDLE, after its result
// is loaded, so a request occupies the block until then.
// With fewer than SHORT_WINDOW samples held, the divider passes are skipped and the zero
// result is offered from S_DONE. The block holds its last step while an earlier result
// waits in the output register.
module load_history_mode_governor #(
    parameter int HISTORY_DEPTH = lhmg_pkg::DEF_HISTORY_DEPTH,
    parameter int SHORT_WINDOW = lhmg_pkg::DEF_SHORT_WINDOW
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lhmg_pkg::LOAD_W-1:0] i_load_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_averages_valid,
    output logic [lhmg_pkg::LOAD_W-1:0] o_short_average,
    output logic [lhmg_pkg::LOAD_W-1:0] o_long_average,
    output logic [1:0]                  o_mode_request,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lhmg_pkg::CFG_AW-1:0] paddr,
    input  logic [lhmg_pkg::CFG_DW-1:0] pwdata,
    output logic [lhmg_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);

    import lhmg_pkg::*;

    localparam int MAX_N = (HISTORY_DEPTH > SHORT_WINDOW) ? HISTORY_DEPTH : SHORT_WINDOW;
    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int IDX_W = SLOT_W + 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int DIV_W = $clog2(MAX_N + 1);
    localparam int SUM_W = $clog2(MAX_N * LOAD_MAX_INT + 1);
    localparam bit SW_FITS = (SHORT_WINDOW <= HISTORY_DEPTH);
    localparam int BACK_OFS = SW_FITS ? (HISTORY_DEPTH - SHORT_WINDOW) : 0;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BACK   = 4'd1;
    localparam logic [3:0] S_OLD    = 4'd2;
    localparam logic [3:0] S_ADD    = 4'd3;
    localparam logic [3:0] S_DIV_S  = 4'd4;
    localparam logic [3:0] S_WAIT_S = 4'd5;
    localparam logic [3:0] S_DIV_L  = 4'd6;
    localparam logic [3:0] S_WAIT_L = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [LOAD_W-1:0] r_high;
    logic [LOAD_W-1:0] r_low_thr;
    logic [LOAD_W-1:0] r_sample;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_held;
    logic [SUM_W-1:0]  r_total;
    logic [SUM_W-1:0]  r_recent;
    logic              r_enough;
    logic [LOAD_W-1:0] r_short;
    logic [LOAD_W-1:0] r_long;

    logic              r_out_valid;
    logic              r_avg_valid;
    logic [LOAD_W-1:0] r_short_out;
    logic [LOAD_W-1:0] r_long_out;
    logic [1:0]        r_mode;

    logic              in_acc;
    logic              cfg_wr;
    logic [LOAD_W-1:0] sat_sample;
    logic [IDX_W-1:0]  back_ext;
    logic [SLOT_W-1:0] back_slot;
    logic              mem_rd_en;
    logic [SLOT_W-1:0] mem_rd_addr;
    logic              mem_wr_en;
    logic [LOAD_W-1:0] mem_rd_data;
    logic              div_start;
    logic [SUM_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic              div_done;
    logic [LOAD_W-1:0] div_quotient;
    logic              out_load;
    logic [1:0]        mode_calc;

    assign in_acc = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    assign sat_sample = (i_load_sample > LOAD_MAX) ? LOAD_MAX : i_load_sample;

    always_comb begin
        back_ext = {1'b0, r_slot} + IDX_W'(BACK_OFS);
        if (back_ext >= IDX_W'(HISTORY_DEPTH)) begin
            back_ext = back_ext - IDX_W'(HISTORY_DEPTH);
        end
        back_slot = back_ext[SLOT_W-1:0];
    end

    assign mem_rd_en = in_acc || (r_state == S_BACK);
    assign mem_rd_addr = (r_state == S_BACK) ? r_slot : back_slot;
    assign mem_wr_en = (r_state == S_OLD);

    lhmg_hist_mem #(
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (SLOT_W),
        .DATA_W (LOAD_W)
    ) u_hist_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_sample),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign div_start = (r_state == S_DIV_L) || ((r_state == S_DIV_S) && r_enough);
    assign div_dividend = (r_state == S_DIV_L) ? r_total : r_recent;
    assign div_divisor = (r_state == S_DIV_L) ? DIV_W'(r_held) : DIV_W'(SHORT_WINDOW);

    lhmg_serial_div #(
        .DVD_W (SUM_W),
        .DSR_W (DIV_W),
        .Q_W   (LOAD_W)
    ) u_serial_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_BACK;
                end
            end
            S_BACK:   n_state = S_OLD;
            S_OLD:    n_state = S_ADD;
            S_ADD:    n_state = S_DIV_S;
            S_DIV_S:  n_state = r_enough ? S_WAIT_S : S_DONE;
            S_WAIT_S: begin
                if (div_done) begin
                    n_state = S_DIV_L;
                end
            end
            S_DIV_L:  n_state = S_WAIT_L;
            S_WAIT_L: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        if (r_short > r_high && r_short > r_long) begin
            mode_calc = MODE_PERF;
        end else if (r_short < r_low_thr && r_short <= r_long) begin
            mode_calc = MODE_SAVER;
        end else begin
            mode_calc = MODE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot <= '0;
            r_held <= '0;
            r_total <= '0;
            r_recent <= '0;
            r_out_valid <= 1'b0;
            r_high <= DEF_HIGH_THRESHOLD;
            r_low_thr <= DEF_LOW_THRESHOLD;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_HIGH_THRESHOLD: r_high <= pwdata[LOAD_W-1:0];
                    REG_LOW_THRESHOLD:  r_low_thr <= pwdata[LOAD_W-1:0];
                    default:            r_high <= r_high;
                endcase
            end
            if (in_acc) begin
                r_sample <= sat_sample;
            end
            if (r_state == S_BACK) begin
                if (SW_FITS && DIV_W'(r_held) >= DIV_W'(SHORT_WINDOW)) begin
                    r_recent <= r_recent - SUM_W'(mem_rd_data);
                end
            end
            if (r_state == S_OLD) begin
                if (r_held >= CNT_W'(HISTORY_DEPTH)) begin
                    r_total <= r_total - SUM_W'(mem_rd_data);
                    r_held <= CNT_W'(HISTORY_DEPTH - 1);
                end
            end
            if (r_state == S_ADD) begin
                r_total <= r_total + SUM_W'(r_sample);
                r_recent <= r_recent + SUM_W'(r_sample);
                r_held <= r_held + 1'b1;
                r_enough <= (DIV_W'(r_held) + 1'b1) >= DIV_W'(SHORT_WINDOW);
                if (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            if (r_state == S_WAIT_S && div_done) begin
                r_short <= div_quotient;
            end
            if (r_state == S_WAIT_L && div_done) begin
                r_long <= div_quotient;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_avg_valid <= r_enough;
                r_short_out <= r_enough ? r_short : '0;
                r_long_out <= r_enough ? r_long : '0;
                r_mode <= r_enough ? mode_calc : MODE_NONE;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HIGH_THRESHOLD: prdata = CFG_DW'(r_high);
            REG_LOW_THRESHOLD:  prdata = CFG_DW'(r_low_thr);
            default:            prdata = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_averages_valid = r_avg_valid;
    assign o_short_average = r_short_out;
    assign o_long_average = r_long_out;
    assign o_mode_request = r_mode;

endmodule

// ===== rtl/lhmg_hist_mem.sv =====
// Sample history memory with one write port and one registered read port.
// Standalone; no package dependency.
module lhmg_hist_mem #(
    parameter int DEPTH = 60,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 14
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lhmg_serial_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Standalone; the caller guarantees that the quotient fits in Q_W bits.
module lhmg_serial_div #(
    parameter int DVD_W = 20,
    parameter int DSR_W = 7,
    parameter int Q_W = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quotient
);

    localparam int STEP_W = $clog2(Q_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DSR_W-1:0]  r_rem;
    logic [DSR_W-1:0]  r_dsr;
    logic [Q_W-1:0]    r_low;

    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    diff;
    logic              fits;
    logic [DSR_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_low[Q_W-1]};
        diff = trial - {1'b0, r_dsr};
        fits = (trial >= {1'b0, r_dsr});
        n_rem = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem <= DSR_W'(i_dividend >> Q_W);
                r_low <= i_dividend[Q_W-1:0];
                r_dsr <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_low <= {r_low[Q_W-2:0], fits};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quotient = r_low;

endmodule
